// File: rtl/logit_argmax_cross_entropy_assert.svh
// assertion macros shared by the argmax and cross-entropy block
`ifndef LOGIT_ARGMAX_CROSS_ENTROPY_ASSERT_SVH
`define LOGIT_ARGMAX_CROSS_ENTROPY_ASSERT_SVH
`ifndef SYNTHESIS
// checked only outside reset
`define LACE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define LACE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LACE_ASSERT(label, prop, msg)
`define LACE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: rtl/lace_pkg.sv
// types, constants and exponent and logarithm tables for the loss block
`timescale 1ns / 1ps

package lace_pkg;

    localparam int LN_BITS      = 10;
    localparam int LN_DEPTH     = 1 << LN_BITS;
    localparam int LN2_Q16      = 45426;
    localparam int LN_OFFSET    = 16 * LN2_Q16;
    localparam int LOSS_CLAMP   = 4126;
    localparam int EXP_RANGE_Q8 = 4096;
    localparam int MUL_W        = 31;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int LOSS_W       = 27;

    typedef logic [MUL_W-1:0] t_q30;
    typedef t_q30 t_ef_tab [256];
    typedef t_q30 t_ei_tab [32];
    typedef logic [15:0] t_ln_val;
    typedef t_ln_val t_ln_tab [LN_DEPTH];

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_DRAIN,
        ST_NORM,
        ST_LN,
        ST_LOSS,
        ST_DONE
    } t_state;

    // shift and subtract division, used only while the tables are built
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-x) in q30 by the alternating series, x in q30 up to one
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] x);
        logic signed [63:0] acc;
        logic [63:0]        t;
        logic               neg;
        logic               done;
        acc  = 64'sd1 <<< 30;
        t    = 64'd1 << 30;
        neg  = 1'b1;
        done = 1'b0;
        for (int n = 1; n < 48; n++) begin
            if (!done) begin
                t = udiv((t * x) >> 30, 64'(n));
                if (t == 64'd0) begin
                    done = 1'b1;
                end else begin
                    if (neg) begin
                        acc = acc - $signed(t);
                    end else begin
                        acc = acc + $signed(t);
                    end
                    neg = !neg;
                end
            end
        end
        return 64'(acc);
    endfunction

    // ln(1 + i / 2^LN_BITS) in q16 through 2 atanh(z)
    function automatic t_ln_val ln1p_q16(input int i);
        logic [63:0] den;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] acc;
        logic [63:0] res;
        den = (64'd1 << (LN_BITS + 1)) + 64'(i);
        z   = udiv(64'(i) << 30, den);
        z2  = (z * z) >> 30;
        p   = z;
        acc = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                acc = acc + udiv(p, 64'(2 * k + 1));
                p   = (p * z2) >> 30;
            end
        end
        res = (2 * acc + (64'd1 << 13)) >> 14;
        return res[15:0];
    endfunction

    function automatic t_ef_tab ef_table();
        t_ef_tab     tab;
        logic [63:0] v;
        for (int k = 0; k < 256; k++) begin
            v      = exp_neg_q30(64'(k) << 22);
            tab[k] = v[MUL_W-1:0];
        end
        return tab;
    endfunction

    // integer part steps; entries past sixteen are never used
    function automatic t_ei_tab ei_table();
        t_ei_tab     tab;
        logic [63:0] e1;
        logic [63:0] v;
        e1     = exp_neg_q30(64'd1 << 30);
        v      = 64'd1 << 30;
        tab[0] = v[MUL_W-1:0];
        tab[1] = e1[MUL_W-1:0];
        v      = e1;
        for (int j = 2; j < 32; j++) begin
            if (j <= 16) begin
                v      = (v * e1 + (64'd1 << 29)) >> 30;
                tab[j] = v[MUL_W-1:0];
            end else begin
                tab[j] = '0;
            end
        end
        return tab;
    endfunction

    function automatic t_ln_tab ln_table();
        t_ln_tab tab;
        for (int i = 0; i < LN_DEPTH; i++) begin
            tab[i] = ln1p_q16(i);
        end
        return tab;
    endfunction

    localparam t_ef_tab EF_TAB = ef_table();
    localparam t_ei_tab EI_TAB = ei_table();
    localparam t_ln_tab LN_TAB = ln_table();

endpackage

// File: rtl/lace_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module lace_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lace_mul.sv
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps

module lace_mul (
    input  logic                        i_clk,
    input  logic [lace_pkg::MUL_W-1:0]  i_a,
    input  logic [lace_pkg::MUL_W-1:0]  i_b,
    output logic [lace_pkg::PROD_W-1:0] o_p
);

    logic [lace_pkg::PROD_W-1:0] r_p;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= lace_pkg::PROD_W'(i_a) * lace_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: rtl/logit_argmax_cross_entropy.sv
// top level: row store, exponent pass, normaliser and loss sequencer
`timescale 1ns / 1ps
`include "logit_argmax_cross_entropy_assert.svh"

// Softmax cross-entropy loss with argmax over one vocabulary row.
// Slave channel: one Q7.8 logit per request in tdata, tuser flags the
// target class, tlast closes the row. Each logit is taken in one cycle.
// Master channel: one result per row, predicted index and unsigned Q5.8 loss.
// After the request with tlast the block drops tready and runs a pass over
// the stored row, one element per cycle through a four stage exponent pipe
// (ram read, table lookup, shared multiplier, accumulate). The sum is then
// normalised one bit a cycle, and the shared multiplier forms e * ln2.
// For a row of N stored elements the normaliser makes at most clog2(VOCAB_MAX) shifts.
// Elements beyond VOCAB_MAX are dropped, a tlast on them still ends the row.
// The result sits in an output register; the block takes the next row while
// it waits, and only holds back at the end of a row if it is still unread.
// Reset (synchronous, active low) empties the row and the output register;
// the row store itself needs no clearing since only written entries are read.
module logit_argmax_cross_entropy #(
    parameter int VOCAB_MAX = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] logit
    input  logic [0:0]  s_axis_tuser,   // [0] is_target
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [9:0] predicted_index, [22:10] loss, [23] zero
);

    localparam int ADDR_W = $clog2(VOCAB_MAX);
    localparam int CNT_W  = $clog2(VOCAB_MAX + 1);
    localparam int SUM_W  = 17 + ADDR_W;
    localparam int SH_W   = $clog2(SUM_W);
    localparam int LW     = lace_pkg::LOSS_W;

    lace_pkg::t_state r_state;
    lace_pkg::t_state n_state;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_pos;
    logic [CNT_W-1:0]          pos_next;
    logic signed [15:0]        r_max;
    logic [ADDR_W-1:0]         r_max_pos;
    logic signed [15:0]        r_target;
    logic [SUM_W-1:0]          r_sum;
    logic [2:0]                r_pipe_v;
    logic [lace_pkg::MUL_W-1:0] r_ei;
    logic [lace_pkg::MUL_W-1:0] r_ef;
    logic                      r_zero;
    logic [SH_W-1:0]           r_shift;
    logic [15:0]               r_ln;
    logic signed [LW-1:0]      r_loss_raw;
    logic                      r_out_valid;
    logic [9:0]                r_out_idx;
    logic [12:0]               r_out_loss;

    logic                      in_acc;
    logic                      row_room;
    logic                      pos_last;
    logic                      norm_end;
    logic                      out_free;
    logic                      out_load;
    logic                      ram_we;
    logic                      ram_re;
    logic [15:0]               ram_rdata;
    logic [lace_pkg::MUL_W-1:0] mul_a;
    logic [lace_pkg::MUL_W-1:0] mul_b;
    logic [lace_pkg::PROD_W-1:0] prod;
    logic [16:0]               gap_q8;
    logic [SH_W-1:0]           e_val;
    logic signed [16:0]        score_gap;
    logic signed [LW-1:0]      loss_sum;
    logic [LW-2:0]             loss_q;
    logic [12:0]               loss_sat;
    logic [31:0]               idx_wide;

    // row store
    lace_ram #(
        .WIDTH (16),
        .DEPTH (VOCAB_MAX)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (r_pos[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // shared multiplier for exponent terms and for e * ln2
    lace_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign row_room = (r_count != CNT_W'(VOCAB_MAX));
    assign pos_next = r_pos + CNT_W'(1);
    assign pos_last = (pos_next == r_count);
    assign norm_end = (r_shift == SH_W'(SUM_W - 1));
    assign out_free = !r_out_valid || m_axis_tready;
    assign e_val    = SH_W'(SUM_W - 1) - r_shift;
    assign gap_q8   = 17'(r_max) - 17'($signed(ram_rdata));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lace_pkg::ST_LOAD: begin
                if (in_acc && s_axis_tlast) begin
                    n_state = lace_pkg::ST_PASS;
                end
            end
            lace_pkg::ST_PASS: begin
                if (pos_last) begin
                    n_state = lace_pkg::ST_DRAIN;
                end
            end
            lace_pkg::ST_DRAIN: begin
                if (r_pipe_v == 3'b000) begin
                    n_state = lace_pkg::ST_NORM;
                end
            end
            lace_pkg::ST_NORM: begin
                if (r_sum[SUM_W-1] || norm_end) begin
                    n_state = lace_pkg::ST_LN;
                end
            end
            lace_pkg::ST_LN:   n_state = lace_pkg::ST_LOSS;
            lace_pkg::ST_LOSS: n_state = lace_pkg::ST_DONE;
            lace_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = lace_pkg::ST_LOAD;
                end
            end
            default: n_state = lace_pkg::ST_LOAD;
        endcase
    end

    // state outputs and multiplier operand select
    always_comb begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        out_load      = 1'b0;
        mul_a         = r_zero ? '0 : r_ei;
        mul_b         = r_ef;
        unique case (r_state)
            lace_pkg::ST_LOAD: s_axis_tready = 1'b1;
            lace_pkg::ST_PASS: ram_re = 1'b1;
            lace_pkg::ST_LN: begin
                mul_a = lace_pkg::MUL_W'(e_val);
                mul_b = lace_pkg::MUL_W'(lace_pkg::LN2_Q16);
            end
            lace_pkg::ST_DONE: out_load = out_free;
            default: begin
            end
        endcase
    end

    assign ram_we = in_acc && row_room;

    // loss assembly and saturation
    assign score_gap = 17'(r_max) - 17'(r_target);
    assign loss_sum  = $signed({1'b0, prod[LW-2:0]})
                     - $signed(LW'(lace_pkg::LN_OFFSET))
                     + $signed(LW'(r_ln))
                     + ($signed(LW'(score_gap)) <<< 8);
    assign loss_q    = r_loss_raw[LW-2:0];

    always_comb begin
        if (r_loss_raw < 0) begin
            loss_sat = '0;
        end else if ((loss_q >> 8) > (LW-1)'(lace_pkg::LOSS_CLAMP)) begin
            loss_sat = 13'(lace_pkg::LOSS_CLAMP);
        end else begin
            loss_sat = loss_q[20:8];
        end
    end

    assign idx_wide = 32'(r_max_pos);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lace_pkg::ST_LOAD;
            r_count     <= '0;
            r_pos       <= '0;
            r_max_pos   <= '0;
            r_target    <= '0;
            r_sum       <= '0;
            r_pipe_v    <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pipe_v <= {r_pipe_v[1:0], ram_re};

            // row load
            if (ram_we) begin
                if (r_count == '0 || $signed(s_axis_tdata) > r_max) begin
                    r_max_pos <= r_count[ADDR_W-1:0];
                end
                if (s_axis_tuser[0]) begin
                    r_target <= $signed(s_axis_tdata);
                end
                r_count <= r_count + CNT_W'(1);
            end

            // pass address
            if (r_state == lace_pkg::ST_PASS) begin
                r_pos <= pos_next;
            end

            // accumulate rounded q16 term
            if (r_pipe_v[2]) begin
                r_sum <= r_sum + SUM_W'(prod[60:44]) + SUM_W'(prod[43]);
            end

            // normalise one bit a cycle
            if (r_state == lace_pkg::ST_NORM && !r_sum[SUM_W-1] && !norm_end) begin
                r_sum   <= r_sum << 1;
                r_shift <= r_shift + SH_W'(1);
            end

            // result register and row clear
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_pos       <= '0;
                r_max_pos   <= '0;
                r_target    <= '0;
                r_sum       <= '0;
                r_shift     <= '0;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ram_we && (r_count == '0 || $signed(s_axis_tdata) > r_max)) begin
            r_max <= $signed(s_axis_tdata);
        end
        if (r_pipe_v[0]) begin
            r_ei   <= lace_pkg::EI_TAB[gap_q8[12:8]];
            r_ef   <= lace_pkg::EF_TAB[gap_q8[7:0]];
            r_zero <= (gap_q8 > 17'(lace_pkg::EXP_RANGE_Q8));
        end
        if (r_state == lace_pkg::ST_LN) begin
            r_ln <= lace_pkg::LN_TAB[r_sum[SUM_W-2 -: lace_pkg::LN_BITS]];
        end
        if (r_state == lace_pkg::ST_LOSS) begin
            r_loss_raw <= loss_sum;
        end
        if (out_load) begin
            r_out_idx  <= idx_wide[9:0];
            r_out_loss <= loss_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_loss, r_out_idx};

    // checks
    `LACE_ASSERT(a_pass_start, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (r_state == lace_pkg::ST_PASS && r_count != '0), "row closed with nothing stored")
    `LACE_ASSERT(a_drain_empty, (r_state == lace_pkg::ST_NORM) |-> (r_pipe_v == 3'b000), "normalising with terms still in flight")
    `LACE_ASSERT(a_sum_floor, (r_state == lace_pkg::ST_NORM && $past(r_state) == lace_pkg::ST_DRAIN) |-> (r_sum >= SUM_W'(65536)), "exponent sum lost the maximum term")
    `LACE_ASSERT(a_norm_done, (r_state == lace_pkg::ST_LN) |-> r_sum[SUM_W-1], "sum not normalised at log lookup")
    `LACE_ASSERT_ALWAYS(a_loss_bound, m_axis_tvalid |-> (r_out_loss <= 13'(lace_pkg::LOSS_CLAMP)), "loss above clamp")

endmodule

// File: test/logit_argmax_cross_entropy_checker.sv
// checker that predicts and compares the argmax and loss of each logit row
`timescale 1ns / 1ps

module logit_argmax_cross_entropy_checker #(
    parameter int VOCAB_MAX = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] logit
    input  logic [0:0]  s_axis_tuser,   // [0] is_target
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [9:0] predicted_index, [22:10] loss, [23] zero
    output int          o_fail_count,
    output int          o_due_count
);

    localparam int LN_BITS    = 10;
    localparam int LN2_Q16    = 45426;
    localparam int LOSS_CLAMP = 4126;
    localparam int EXP_SPAN   = 4096;

    typedef struct packed {
        logic [9:0]  index;
        logic [12:0] loss;
    } t_row_result;

    // exponent and logarithm tables
    longint unsigned exp_whole [17];
    longint unsigned exp_frac [256];
    int              ln_frac [1 << LN_BITS];

    // row being collected
    int row_logits [VOCAB_MAX];
    int row_len      = 0;
    int row_peak     = 0;
    int peak_pos     = 0;
    int target_logit = 0;

    t_row_result results_due [$];
    int          fails = 0;

    // exp(-x) in q30 by the alternating series
    function automatic longint unsigned exp_neg_q30(input longint unsigned x);
        longint          acc;
        longint unsigned t;
        bit              neg;
        bit              done;
        acc  = 64'sd1 <<< 30;
        t    = 64'd1 << 30;
        neg  = 1'b1;
        done = 1'b0;
        for (longint unsigned n = 1; n < 48; n++) begin
            if (!done) begin
                t = ((t * x) >> 30) / n;
                if (t == 0) begin
                    done = 1'b1;
                end else begin
                    if (neg) begin
                        acc = acc - longint'(t);
                    end else begin
                        acc = acc + longint'(t);
                    end
                    neg = !neg;
                end
            end
        end
        return unsigned'(acc);
    endfunction

    // ln(1 + i / 2^LN_BITS) in q16 via 2 atanh(z)
    function automatic int ln1p_q16(input longint unsigned i);
        longint unsigned den;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned acc;
        den = (64'd1 << (LN_BITS + 1)) + i;
        z   = (i << 30) / den;
        z2  = (z * z) >> 30;
        p   = z;
        acc = 0;
        for (longint unsigned k = 0; k < 64; k++) begin
            if (p != 0) begin
                acc = acc + p / (2 * k + 1);
                p   = (p * z2) >> 30;
            end
        end
        return int'((2 * acc + (64'd1 << 13)) >> 14);
    endfunction

    // one exponential term in q16, d is the distance below the peak in q8
    function automatic longint unsigned exp_term_q16(input int d);
        if (d < 0 || d > EXP_SPAN) begin
            return 0;
        end
        return (exp_whole[d >> 8] * exp_frac[d & 255] + (64'd1 << 43)) >> 44;
    endfunction

    // second pass over the row: argmax and clamped q5.8 loss
    function automatic t_row_result close_row();
        longint unsigned sum;
        int              e;
        int              idx;
        longint          loss;
        t_row_result     res;
        sum = 0;
        for (int i = 0; i < row_len; i++) begin
            sum = sum + exp_term_q16(row_peak - row_logits[i]);
        end
        e = 0;
        while (e < 63 && (sum >> (e + 1)) != 0) begin
            e++;
        end
        if (e >= LN_BITS) begin
            idx = int'(sum >> (e - LN_BITS));
        end else begin
            idx = int'(sum << (LN_BITS - e));
        end
        idx  = idx & ((1 << LN_BITS) - 1);
        loss = longint'(e - 16) * LN2_Q16 + ln_frac[idx]
             + 256 * longint'(row_peak - target_logit);
        if (loss < 0) begin
            loss = 0;
        end
        loss = loss >>> 8;
        if (loss > LOSS_CLAMP) begin
            loss = LOSS_CLAMP;
        end
        res.index = peak_pos[9:0];
        res.loss  = loss[12:0];
        return res;
    endfunction

    task automatic report_fault(input string what);
        $display("%0t ns checker: %s", $realtime, what);
        fails++;
    endtask

    task automatic clear_row();
        row_len      = 0;
        row_peak     = 0;
        peak_pos     = 0;
        target_logit = 0;
    endtask

    // absorb one accepted logit request
    task automatic take_logit(input int v, input bit tgt, input bit last);
        if (row_len < VOCAB_MAX) begin
            row_logits[row_len] = v;
            if (row_len == 0 || v > row_peak) begin
                row_peak = v;
                peak_pos = row_len;
            end
            if (tgt) begin
                target_logit = v;
            end
            row_len++;
        end
        if (last) begin
            results_due.push_back(close_row());
            clear_row();
        end
    endtask

    // table build
    initial begin
        exp_whole[0] = 64'd1 << 30;
        exp_whole[1] = exp_neg_q30(64'd1 << 30);
        for (int j = 2; j < 17; j++) begin
            exp_whole[j] = (exp_whole[j-1] * exp_whole[1] + (64'd1 << 29)) >> 30;
        end
        for (int k = 0; k < 256; k++) begin
            exp_frac[k] = exp_neg_q30(64'(k) << 22);
        end
        for (int i = 0; i < (1 << LN_BITS); i++) begin
            ln_frac[i] = ln1p_q16(i);
        end
    end

    // watch both channels, results before requests in the same cycle
    always @(posedge i_clk) begin : watch
        t_row_result want;
        if (!i_rst_n) begin
            clear_row();
            results_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    report_fault($sformatf("result index %0d loss %0d with nothing due",
                                           m_axis_tdata[9:0], m_axis_tdata[22:10]));
                end else begin
                    want = results_due.pop_front();
                    if (m_axis_tdata[9:0] !== want.index) begin
                        report_fault($sformatf("predicted_index got %0d want %0d",
                                               m_axis_tdata[9:0], want.index));
                    end
                    if (m_axis_tdata[22:10] !== want.loss) begin
                        report_fault($sformatf("loss got %0d want %0d",
                                               m_axis_tdata[22:10], want.loss));
                    end
                    if (m_axis_tdata[23] !== 1'b0) begin
                        report_fault("pad bit of result not zero");
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_logit($signed(s_axis_tdata), s_axis_tuser[0], s_axis_tlast);
            end
        end
        o_fail_count <= fails;
        o_due_count  <= results_due.size();
    end

endmodule

// File: test/logit_argmax_cross_entropy_tb.sv
// top of the argmax and cross-entropy testbench: clock, reset, stimulus, verdict
`timescale 1ns / 1ps

module logit_argmax_cross_entropy_tb;

    localparam int VOCAB     = 1024;
    localparam int LIMIT     = 1000000;
    localparam int LONG_HOLD = 400;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] logit
    logic [0:0]  s_axis_tuser  = '0;   // [0] is_target
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [9:0] predicted_index, [22:10] loss, [23] zero

    int fail_count;
    int due_count;
    int cycle_count = 0;
    int items_sent  = 0;
    int rows_sent   = 0;
    int calm_rows   = 0;
    bit hold_off_req = 1'b0;

    logit_argmax_cross_entropy #(
        .VOCAB_MAX(VOCAB)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    logit_argmax_cross_entropy_checker #(
        .VOCAB_MAX(VOCAB)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // idle gap lengths, mostly short with the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic int pick_row_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 16);
        end else if (r < 95) begin
            return $urandom_range(17, 64);
        end
        return $urandom_range(65, 200);
    endfunction

    // offer one logit request and wait for it to be taken
    task automatic push_logit(input logic [15:0] v, input bit tgt, input bit last);
        int gap;
        gap = (calm_rows > 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= tgt;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // one row with random content, target placement and value spread
    task automatic random_row(input int len);
        int          style;
        int          tgt_mode;
        int          tgt_pos;
        int          spread;
        logic [15:0] base;
        logic [15:0] v;
        bit          tgt;
        style    = $urandom_range(0, 9);
        tgt_mode = $urandom_range(0, 19);
        tgt_pos  = $urandom_range(0, len - 1);
        spread   = $urandom_range(0, 4200);
        base     = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            if (style < 3) begin
                v = 16'($urandom);
            end else if (style < 8) begin
                v = base - 16'($urandom_range(0, spread));
            end else begin
                v = base - 16'(256 * $urandom_range(0, 2));
            end
            if (tgt_mode < 12) begin
                tgt = (i == tgt_pos);
            end else if (tgt_mode < 15) begin
                tgt = 1'b0;
            end else begin
                tgt = ($urandom_range(0, 3) == 0);
            end
            push_logit(v, tgt, i == len - 1);
        end
        rows_sent++;
        if (calm_rows > 0) begin
            calm_rows--;
        end else if ($urandom_range(0, 7) == 0) begin
            calm_rows = 1;
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single element row at the top of the range
        push_logit(16'h7FFF, 1'b1, 1'b1);
        // most negative against most positive, target far below the peak
        push_logit(16'h8000, 1'b1, 1'b0);
        push_logit(16'h7FFF, 1'b0, 1'b1);
        // ties, first maximum wins
        push_logit(16'h0100, 1'b0, 1'b0);
        push_logit(16'h0100, 1'b1, 1'b0);
        push_logit(16'h0100, 1'b0, 1'b1);
        // no target flagged
        push_logit(16'hFFFB, 1'b0, 1'b0);
        push_logit(16'h0003, 1'b0, 1'b0);
        push_logit(16'h0007, 1'b0, 1'b1);
        // several targets, the later one counts
        push_logit(16'h000A, 1'b1, 1'b0);
        push_logit(16'h012C, 1'b0, 1'b0);
        push_logit(16'h00C8, 1'b1, 1'b0);
        push_logit(16'h0032, 1'b0, 1'b1);
        // distances of exactly and just past sixteen below the peak
        push_logit(16'h0000, 1'b0, 1'b0);
        push_logit(16'hF000, 1'b1, 1'b0);   // -4096
        push_logit(16'hEFFF, 1'b0, 1'b1);   // -4097
        // all negative, peak not in front
        push_logit(16'hFF38, 1'b0, 1'b0);   // -200
        push_logit(16'hFF9C, 1'b1, 1'b0);   // -100
        push_logit(16'hFED4, 1'b0, 1'b1);   // -300

        // random rows, one of them filling the store and running past it
        while (items_sent < 2000) begin
            if (rows_sent == 3) begin
                hold_off_req = 1'b1;
                calm_rows    = 5;
            end
            if (rows_sent == 10) begin
                len = VOCAB + 3;
            end else begin
                len = pick_row_len();
            end
            random_row(len);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        // drain
        while (due_count != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/lace_pkg.sv
rtl/lace_ram.sv
rtl/lace_mul.sv
rtl/logit_argmax_cross_entropy.sv
test/logit_argmax_cross_entropy_checker.sv
test/logit_argmax_cross_entropy_tb.sv
